// ===== src/dcf_pkg.sv =====
// Shared types and constants for the double to custom float converter.
package dcf_pkg;

  localparam int SigWindowDefault = 64;
  localparam int PrecW = 6;
  localparam int ExpW = 12;
  localparam int MantW = 63;
  localparam int FifoDepth = 2;

  localparam logic [1:0] RegPrecision = 2'd0;
  localparam logic [1:0] RegExpUpper = 2'd1;
  localparam logic [1:0] RegExpLower = 2'd2;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic             sign_bit;
    logic [ExpW-1:0]  exponent;
    logic [52:0]      sig;
    logic             zero_input;
    logic             not_finite;
  } class_item_t;

  typedef struct packed {
    logic             sign_bit;
    logic [ExpW-1:0]  exponent;
    logic [MantW-1:0] mantissa;
    logic [MantW-1:0] ones_complement;
    logic [MantW-1:0] twos_complement;
    logic             truncated;
    logic             overflow;
    logic             underflow;
    logic             zero_input;
    logic             not_finite;
  } result_t;

endpackage

// ===== src/dcf_front.sv =====
// Front end: decodes the double, normalizes subnormals and registers the item.
module dcf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [63:0]          value_bits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcf_pkg::class_item_t out_item
);
  import dcf_pkg::*;

  logic        in_ready;
  logic [10:0] efield;
  logic [51:0] frac;
  logic [5:0]  lz;
  logic        found;
  class_item_t item_next;

  assign in_ready = !out_valid || out_ready;
  assign efield = value_bits[62:52];
  assign frac = value_bits[51:0];

  // Leading zero count of the fraction for subnormal inputs.
  always_comb begin
    lz = 6'd0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && frac[i]) begin
        found = 1'b1;
        lz = 6'(51 - i);
      end
    end
  end

  always_comb begin
    item_next = '0;
    if (efield == 11'h7FF) begin
      item_next.not_finite = 1'b1;
    end else if (efield == 11'd0 && frac == 52'd0) begin
      item_next.zero_input = 1'b1;
    end else if (efield != 11'd0) begin
      item_next.sign_bit = value_bits[63];
      item_next.sig = {1'b1, frac};
      item_next.exponent = ExpW'({1'b0, efield}) - ExpW'(1022);
    end else begin
      item_next.sign_bit = value_bits[63];
      item_next.sig = {1'b0, frac} << (lz + 6'd1);
      item_next.exponent = ExpW'(-1022) - ExpW'(lz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== src/dcf_fifo.sv =====
// Small queue between the front end and the back end.
module dcf_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  dcf_pkg::class_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output dcf_pkg::class_item_t rd_item
);
  import dcf_pkg::*;

  class_item_t mem [FifoDepth];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign wr_ready = count != 2'(FifoDepth);
  assign rd_valid = count != 2'd0;
  assign rd_item = mem[rd_ptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== src/dcf_back.sv =====
// Back end: truncation to the set precision, complements and limit checks.
module dcf_back #(
  parameter int SIG_WINDOW = dcf_pkg::SigWindowDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dcf_pkg::class_item_t          in_item,
  input  logic [dcf_pkg::PrecW-1:0]     precision_bits,
  input  logic signed [dcf_pkg::ExpW-1:0] exponent_upper,
  input  logic signed [dcf_pkg::ExpW-1:0] exponent_lower,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dcf_pkg::result_t              out_res
);
  import dcf_pkg::*;

  // Bits of the 53-bit significand hidden by a window narrower than 53.
  localparam int Cut = (SIG_WINDOW < 53) ? 53 - SIG_WINDOW : 0;

  logic [52:0]      sig_w;
  logic [52:0]      cut_mask;
  logic [116:0]     wide;
  logic [116:0]     shifted;
  logic [52:0]      low_bits;
  logic [MantW-1:0] mask;
  logic [MantW-1:0] mant;
  logic [MantW-1:0] ones;
  logic signed [ExpW-1:0] e;
  result_t          res_next;

  assign in_ready = !out_valid || out_ready;
  assign cut_mask = ~((53'd1 << Cut) - 53'd1);
  assign sig_w = in_item.sig & cut_mask;
  assign e = in_item.exponent;

  // Significand placed at the top of a 53+64 bit field, then shifted so
  // the first precision_bits bits land right aligned at the bottom.
  assign wide = {sig_w, 64'd0};
  assign shifted = wide >> (7'd117 - 7'(precision_bits));
  assign low_bits = wide[116:64] & ((53'd1 << (7'd53 - 7'(precision_bits))) - 53'd1);

  always_comb begin
    mask = (MantW'(1) << precision_bits) - MantW'(1);
    mant = MantW'(shifted) & mask;
    ones = ~mant & mask;
    res_next = '0;
    res_next.zero_input = in_item.zero_input;
    res_next.not_finite = in_item.not_finite;
    if (!in_item.zero_input && !in_item.not_finite) begin
      res_next.sign_bit = in_item.sign_bit;
      res_next.exponent = in_item.exponent;
      res_next.mantissa = mant;
      res_next.ones_complement = ones;
      res_next.twos_complement = (ones + MantW'(1)) & mask;
      res_next.truncated = ((in_item.sig & ~cut_mask) != 53'd0) ||
                           (precision_bits <= 6'd53 && low_bits != 53'd0);
      res_next.overflow = exponent_upper != '0 && e > exponent_upper;
      res_next.underflow = exponent_lower != '0 && e < exponent_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= res_next;
    end
  end

endmodule

// ===== src/double_to_custom_float_truncate_top.sv =====
// Top level of the double to custom float converter with truncation.
//
// Converts the raw bits of an IEEE double into sign, 0.1xxx times 2^exponent,
// keeping precision_bits significand bits by truncation, with complements and
// limit flags. A beat enters whenever full is low and leaves whenever empty is
// low and pop is high; one beat per cycle is sustained while pop is held high. The
// front end decodes and normalizes into its register, the beat is then written
// into a two-entry queue, and the back end truncates, forms the complements and
// checks the exponent limits into its result register. Configuration writes take
// effect on the next cycle and should be made only while no beat is in flight.
module double_to_custom_float_truncate_top #(
  parameter int SIG_WINDOW = dcf_pkg::SigWindowDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [63:0]                     value_bits,
  output logic                            empty,
  input  logic                            pop,
  output logic                            sign_bit,
  output logic signed [dcf_pkg::ExpW-1:0] exponent,
  output logic [dcf_pkg::MantW-1:0]       mantissa,
  output logic [dcf_pkg::MantW-1:0]       ones_complement,
  output logic [dcf_pkg::MantW-1:0]       twos_complement,
  output logic                            truncated,
  output logic                            overflow,
  output logic                            underflow,
  output logic                            zero_input,
  output logic                            not_finite,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [dcf_pkg::ExpW-1:0]        cfg_data
);
  import dcf_pkg::*;

  logic [PrecW-1:0]       precision_bits;
  logic signed [ExpW-1:0] exponent_upper;
  logic signed [ExpW-1:0] exponent_lower;
  logic                   fr_valid;
  logic                   fr_ready;
  class_item_t            fr_item;
  logic                   q_valid;
  logic                   q_ready;
  class_item_t            q_item;
  logic                   bk_valid;
  result_t                res;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      precision_bits <= PrecW'(24);
      exponent_upper <= '0;
      exponent_lower <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPrecision: precision_bits <= cfg_data[PrecW-1:0];
        RegExpUpper:  exponent_upper <= cfg_data;
        RegExpLower:  exponent_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  dcf_front u_front (
    .clk(clk), .rst(rst), .in_valid(push), .value_bits(value_bits),
    .out_valid(fr_valid), .out_ready(fr_ready), .out_item(fr_item)
  );

  // The front end stalls with the queue, so full follows the front stage.
  assign full = fr_valid && !fr_ready;

  dcf_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_item(fr_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  dcf_back #(.SIG_WINDOW(SIG_WINDOW)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .precision_bits(precision_bits), .exponent_upper(exponent_upper),
    .exponent_lower(exponent_lower), .out_valid(bk_valid), .out_ready(pop),
    .out_res(res)
  );

  assign empty = !bk_valid;
  assign sign_bit = res.sign_bit;
  assign exponent = res.exponent;
  assign mantissa = res.mantissa;
  assign ones_complement = res.ones_complement;
  assign twos_complement = res.twos_complement;
  assign truncated = res.truncated;
  assign overflow = res.overflow;
  assign underflow = res.underflow;
  assign zero_input = res.zero_input;
  assign not_finite = res.not_finite;

  // A result never flags zero and not finite together.
  assert property (@(posedge clk) disable iff (rst) !empty |-> !(zero_input && not_finite))
    else $error("zero and not finite flagged together");

  // A waiting result holds while it is not popped.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(mantissa)))
    else $error("result changed while stalled");

  // Special inputs carry an all-zero payload.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (zero_input || not_finite)) |-> (mantissa == '0 && !sign_bit))
    else $error("special input with nonzero payload");

endmodule
